@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro assumes clk_i and rst_ni are visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered list check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered list check failed");

`endif

@@ rtl/olie_pkg.sv @@
// Package for the ordered list: sizes, request and status codes, beat structs.
// No dependencies; imported by every other file of the block but assert_macros.svh.
package olie_pkg;

  localparam int CAPACITY      = 16;
  localparam int ELEMENT_WIDTH = 32;

  // Count holds 0..CAPACITY, a cell index 0..CAPACITY-1.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ERASE  = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_BADPOS = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  position;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element;
    logic [4:0]  list_size;
    logic        last;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_ERASE,
    CMD_ROTATE
  } cmd_e;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cmd_e             op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    elem_t            value;
  } chain_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

endpackage

@@ rtl/olie_cell.sv @@
// One storage cell of the list chain.
// Depends on olie_pkg for the command struct and element type.
module olie_cell
  import olie_pkg::*;
(
  input  logic             clk_i,
  input  logic [CNT_W-1:0] index_i,
  input  chain_cmd_t       cmd_i,
  input  elem_t            left_i,
  input  elem_t            right_i,
  input  elem_t            wrap_i,
  output elem_t            value_o
);

  elem_t value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      CMD_INSERT: begin
        if (index_i > cmd_i.pos) begin
          value_d = left_i;
        end else if (index_i == cmd_i.pos) begin
          value_d = cmd_i.value;
        end
      end
      CMD_ERASE: begin
        if (index_i >= cmd_i.pos) begin
          value_d = right_i;
        end
      end
      CMD_ROTATE: begin
        // cnt is non-zero whenever a rotate is issued
        if (index_i == cmd_i.cnt - CNT_W'(1)) begin
          value_d = wrap_i;
        end else if (index_i < cmd_i.cnt - CNT_W'(1)) begin
          value_d = right_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ rtl/olie_ctrl.sv @@
// Request sequencer: size count, dump walk, result register, chain commands.
// Depends on olie_pkg.
module olie_ctrl
  import olie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  req_t       req_i,
  input  elem_t      head_i,
  output logic       busy_o,
  output logic       done_o,
  output rsp_t       rsp_o,
  output chain_cmd_t cmd_o
);

  localparam int PW = (CNT_W > 5) ? CNT_W : 5;
  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             full, empty, dump_last;
  logic [PW-1:0]    pos_w, cnt_w;
  logic [63:0]      head_ext;

  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign pos_w     = PW'(req_i.position);
  assign cnt_w     = PW'(count_q);
  assign dump_last = (CNT_W'(idx_q) == count_q - CNT_W'(1));
  assign head_ext  = 64'(head_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && req_i.req_type == REQ_DUMP && !empty) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (dump_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    rsp_d     = '0;
    cmd_o.op  = CMD_HOLD;
    cmd_o.pos = CNT_W'(req_i.position);
    cmd_o.cnt = count_q;
    cmd_o.value = elem_t'(req_i.item_value);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rsp_d.last = 1'b1;
          case (req_i.req_type)
            REQ_INSERT: begin
              done_d = 1'b1;
              if (full) begin
                rsp_d.status = STAT_FULL;
              end else if (pos_w > cnt_w) begin
                rsp_d.status = STAT_BADPOS;
              end else begin
                cmd_o.op     = CMD_INSERT;
                count_d      = count_q + CNT_W'(1);
                rsp_d.status = STAT_OK;
              end
            end
            REQ_ERASE: begin
              done_d = 1'b1;
              if (empty) begin
                rsp_d.status = STAT_EMPTY;
              end else if (pos_w >= cnt_w) begin
                rsp_d.status = STAT_BADPOS;
              end else begin
                cmd_o.op     = CMD_ERASE;
                count_d      = count_q - CNT_W'(1);
                rsp_d.status = STAT_OK;
              end
            end
            REQ_DUMP: begin
              idx_d = '0;
              if (empty) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_EMPTY;
              end
            end
            default: begin
              rsp_d.last = 1'b0;
            end
          endcase
          rsp_d.list_size = 5'(count_d);
        end
      end
      ST_DUMP: begin
        // emit the head cell, then rotate it to the back of the live region
        done_d          = 1'b1;
        rsp_d.status    = STAT_OK;
        rsp_d.element   = head_ext[31:0];
        rsp_d.list_size = 5'(count_q);
        rsp_d.last      = dump_last;
        cmd_o.op        = CMD_ROTATE;
        idx_d           = idx_q + IW'(1);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q == ST_DUMP);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ rtl/ordered_list_insert_erase.sv @@
// Ordered list top level: a chain of CAPACITY cells plus the request sequencer.
// Insert and erase: one beat in, one result beat in the next cycle; a new request every cycle
// while no dump is running. Dump: busy while walking, one result beat per element, results
// registered in the cycle after each cell is read; the walk covers one cell per cycle.
// Async active-low reset empties the list; cell contents are not cleared.
// Depends on olie_pkg, olie_cell and olie_ctrl.
module ordered_list_insert_erase
  import olie_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  // Command broadcast to every cell in the same cycle
  chain_cmd_t cmd;

  // Cell outputs; index 0 is the head of the list
  elem_t      cell_val [CAPACITY];

  // The sequencer accepts a beat when start_i is high and it is not busy walking
  // a dump. Results leave through a register, so the next request can be taken
  // while the previous result beat is on the ports.
  olie_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .head_i  (cell_val[0]),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .cmd_o   (cmd)
  );

  // Each cell sees both neighbours: insert pulls from the left, erase and the
  // dump rotation pull from the right. The head value wraps to the last live
  // cell during a dump, so after size steps the list is back in place.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    elem_t left_val, right_val;

    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    olie_cell u_cell (
      .clk_i   (clk_i),
      .index_i (CNT_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_val),
      .right_i (right_val),
      .wrap_i  (cell_val[0]),
      .value_o (cell_val[g])
    );
  end

endmodule

@@ rtl/olie_checker.sv @@
// Port-level checks for the ordered list, bound to the top level.
// Depends on olie_pkg and assert_macros.svh.
`include "assert_macros.svh"

module olie_checker
  import olie_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic done_o,
  input rsp_t rsp_o
);

  // an insert or erase beat taken at this edge
  logic shift_beat;

  assign shift_beat = start_i && !busy_o &&
                      (req_i.req_type == REQ_INSERT || req_i.req_type == REQ_ERASE);

  // insert and erase always answer with a single final beat in the next cycle
  `ASSERT_NEXT(a_single_reply, shift_beat, done_o && rsp_o.last)

  // size never runs past capacity
  `ASSERT_IMPL(a_size_bound, done_o, rsp_o.list_size <= 5'(CAPACITY))

  // a dump walk ends with its final beat on the ports
  `ASSERT_IMPL(a_dump_end, $fell(busy_o), done_o && rsp_o.last && rsp_o.status == STAT_OK)

  // error beats are final and carry no element
  `ASSERT_IMPL(a_error_beat, done_o && rsp_o.status != STAT_OK, rsp_o.last && rsp_o.element == '0)

endmodule

bind ordered_list_insert_erase olie_checker u_olie_checker (.*);
